### rtl/kpsm_pkg.sv
// ----------------------------------------------------------------------------
// kpsm_pkg
// Shared types and constants of the keystroke passphrase suffix matcher.
// ----------------------------------------------------------------------------
package kpsm_pkg;

    // field and register widths
    localparam int KEY_W     = 8;
    localparam int LEN_W     = 6;
    localparam int CIDX_W    = 5;
    localparam int CHARS_W   = 64;
    localparam int PHRASE_W  = 4 * CHARS_W;
    localparam int REG_IDX_W = 3;

    // key codes
    localparam logic [KEY_W-1:0] CODE_BACKSPACE       = 8'h08;
    localparam logic [KEY_W-1:0] CODE_DELETE          = 8'h7F;
    localparam logic [KEY_W-1:0] CODE_FIRST_PRINTABLE = 8'h20;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LENGTH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CHARS_0 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CHARS_1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CHARS_2 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CHARS_3 = 3'd5;

    // operation codes from front to back
    typedef logic [1:0] t_op_code;
    localparam t_op_code OP_NONE   = 2'd0;
    localparam t_op_code OP_CLEAR  = 2'd1;
    localparam t_op_code OP_ERASE  = 2'd2;
    localparam t_op_code OP_APPEND = 2'd3;

    typedef struct packed {
        t_op_code         op;
        logic [KEY_W-1:0] key;
    } t_op;

    typedef struct packed {
        logic                enable;
        logic [LEN_W-1:0]    len;
        logic [PHRASE_W-1:0] chars;
    } t_cfg;

endpackage

### rtl/kpsm_ram.sv
// ----------------------------------------------------------------------------
// kpsm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/kpsm_front.sv
// ----------------------------------------------------------------------------
// kpsm_front
// Accepts input items and classifies each into a store operation.
// ----------------------------------------------------------------------------
module kpsm_front #(
    parameter int MAX_PHRASE = 32
) (
    input  kpsm_pkg::t_cfg              i_cfg,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [kpsm_pkg::KEY_W-1:0]  s_axis_tdata,
    input  logic                        s_axis_tuser,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output kpsm_pkg::t_op               o_q_op
);
    import kpsm_pkg::*;

    logic w_phrase_ok;
    logic w_is_erase;
    logic w_is_print;

    // passphrase usable only when enabled with a length in range
    assign w_phrase_ok = i_cfg.enable && (i_cfg.len != '0)
                         && (i_cfg.len <= LEN_W'(MAX_PHRASE));
    assign w_is_erase  = (s_axis_tdata == CODE_BACKSPACE) || (s_axis_tdata == CODE_DELETE);
    assign w_is_print  = (s_axis_tdata >= CODE_FIRST_PRINTABLE) && (s_axis_tdata < CODE_DELETE);

    // handshake with the queue
    assign s_axis_tready = !i_q_full;
    assign o_q_push      = s_axis_tvalid && !i_q_full;

    // classify the item
    always_comb begin
        o_q_op.key = s_axis_tdata;
        priority if (s_axis_tuser) begin
            o_q_op.op = OP_CLEAR;
        end else if (!w_phrase_ok) begin
            o_q_op.op = OP_NONE;
        end else if (w_is_erase) begin
            o_q_op.op = OP_ERASE;
        end else if (w_is_print) begin
            o_q_op.op = OP_APPEND;
        end else begin
            o_q_op.op = OP_NONE;
        end
    end

endmodule

### rtl/kpsm_fifo.sv
// ----------------------------------------------------------------------------
// kpsm_fifo
// Two-entry operation queue between the front and the back.
// ----------------------------------------------------------------------------
module kpsm_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kpsm_pkg::t_op  i_op,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output kpsm_pkg::t_op  o_op
);
    import kpsm_pkg::*;

    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

### rtl/kpsm_back.sv
// ----------------------------------------------------------------------------
// kpsm_back
// Executes store operations on a circular character RAM and compares the
// newest characters with the passphrase, one character per cycle.
// ----------------------------------------------------------------------------
module kpsm_back #(
    parameter int STORE_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kpsm_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  kpsm_pkg::t_op  i_q_op,
    output logic           o_q_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [7:0]     m_axis_tdata
);
    import kpsm_pkg::*;

    localparam int PW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int SW = PW + 1;
    localparam logic [SW-1:0] DEPTH_X = SW'(STORE_DEPTH);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_CMP  = 1'b1;

    logic              r_state, n_state;
    logic [PW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [PW-1:0]     r_rd_addr, n_rd_addr;
    logic [LEN_W-1:0]  r_issue, n_issue;
    logic              r_chk_pend, n_chk_pend;
    logic [CIDX_W-1:0] r_chk_idx, n_chk_idx;
    logic              r_match, n_match;
    logic              r_out_valid, n_out_valid;
    logic              r_out_match, n_out_match;

    logic              w_out_free;
    logic              w_full;
    logic [PW-1:0]     w_head_inc;
    logic [SW-1:0]     w_tail_sum;
    logic [PW-1:0]     w_tail;
    logic [PW-1:0]     w_head_new;
    logic [CW-1:0]     w_count_new;
    logic [SW-1:0]     w_start_sum;
    logic [PW-1:0]     w_start;
    logic [PW-1:0]     w_rd_inc;
    logic              w_we;
    logic [PW-1:0]     w_waddr;
    logic              w_re;
    logic [KEY_W-1:0]  w_rdata;
    logic [KEY_W-1:0]  w_phrase_byte;
    logic              w_eq;
    logic              w_last;

    kpsm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_q_op.key),
        .i_re    (w_re),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    // circular pointer arithmetic
    assign w_full      = (r_count == CW'(STORE_DEPTH));
    assign w_head_inc  = (r_head == PW'(STORE_DEPTH - 1)) ? '0 : r_head + PW'(1);
    assign w_tail_sum  = SW'(r_head) + SW'(r_count);
    assign w_tail      = (w_tail_sum >= DEPTH_X) ? PW'(w_tail_sum - DEPTH_X) : PW'(w_tail_sum);
    assign w_head_new  = w_full ? w_head_inc : r_head;
    assign w_count_new = w_full ? r_count : r_count + CW'(1);
    assign w_start_sum = SW'(w_head_new) + SW'(w_count_new) - SW'(i_cfg.len);
    assign w_start     = (w_start_sum >= DEPTH_X) ? PW'(w_start_sum - DEPTH_X)
                                                  : PW'(w_start_sum);
    assign w_rd_inc    = (r_rd_addr == PW'(STORE_DEPTH - 1)) ? '0 : r_rd_addr + PW'(1);

    // compare of one character against the passphrase
    assign w_phrase_byte = i_cfg.chars[{r_chk_idx, 3'b000} +: KEY_W];
    assign w_eq          = (w_rdata == w_phrase_byte);
    assign w_last        = (r_chk_idx == CIDX_W'(i_cfg.len - LEN_W'(1)));

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid && w_out_free;
    assign w_we       = o_q_pop && (i_q_op.op == OP_APPEND);
    assign w_waddr    = w_full ? r_head : w_tail;
    assign w_re       = (r_state == S_CMP) && (r_issue < i_cfg.len);

    // operation sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_rd_addr   = r_rd_addr;
        n_issue     = r_issue;
        n_chk_pend  = r_chk_pend;
        n_chk_idx   = r_chk_idx;
        n_match     = r_match;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_match = r_out_match;
        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    unique case (i_q_op.op)
                        OP_CLEAR: begin
                            n_count     = '0;
                            n_out_valid = 1'b1;
                            n_out_match = 1'b0;
                        end
                        OP_ERASE: begin
                            if (r_count != '0) begin
                                n_count = r_count - CW'(1);
                            end
                            n_out_valid = 1'b1;
                            n_out_match = 1'b0;
                        end
                        OP_APPEND: begin
                            n_head  = w_head_new;
                            n_count = w_count_new;
                            if (SW'(w_count_new) < SW'(i_cfg.len)) begin
                                n_out_valid = 1'b1;
                                n_out_match = 1'b0;
                            end else begin
                                n_state    = S_CMP;
                                n_rd_addr  = w_start;
                                n_issue    = '0;
                                n_chk_pend = 1'b0;
                                n_match    = 1'b1;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_match = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                // issue one read per cycle, check the previous one
                if (w_re) begin
                    n_rd_addr  = w_rd_inc;
                    n_issue    = r_issue + LEN_W'(1);
                    n_chk_pend = 1'b1;
                    n_chk_idx  = CIDX_W'(r_issue);
                end else begin
                    n_chk_pend = 1'b0;
                end
                if (r_chk_pend) begin
                    n_match = r_match && w_eq;
                    if (w_last) begin
                        n_state     = S_IDLE;
                        n_chk_pend  = 1'b0;
                        n_out_valid = 1'b1;
                        n_out_match = r_match && w_eq;
                    end
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rd_addr   <= '0;
            r_issue     <= '0;
            r_chk_pend  <= 1'b0;
            r_chk_idx   <= '0;
            r_match     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_match <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rd_addr   <= n_rd_addr;
            r_issue     <= n_issue;
            r_chk_pend  <= n_chk_pend;
            r_chk_idx   <= n_chk_idx;
            r_match     <= n_match;
            r_out_valid <= n_out_valid;
            r_out_match <= n_out_match;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_match};

`ifndef SYNTHESIS
    // fill count never exceeds the store depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    // head pointer stays inside the store
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < PW'(STORE_DEPTH - 1) || r_head == PW'(STORE_DEPTH - 1))
        else $error("head pointer out of range");

    // no result is pending while a compare runs
    a_cmp_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> !r_out_valid)
        else $error("result pending during compare");

    // a compare check only happens inside a compare
    a_chk_in_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_pend |-> (r_state == S_CMP))
        else $error("character check outside compare");

    // a compare ends with a result
    a_cmp_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) && (n_state == S_IDLE) |=> r_out_valid)
        else $error("compare ended without result");
`endif

endmodule

### rtl/keystroke_passphrase_suffix_matcher.sv
// ----------------------------------------------------------------------------
// keystroke_passphrase_suffix_matcher
// Keeps an edited store of typed characters and flags when the newest ones
// equal the configured passphrase.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tdata[7:0] key_code, tuser[0] mode (1 clears store)
//  m_axis    | out       | tdata[0] matched, tdata[7:1] zero
//  cfg       | in        | i_cfg_we, i_cfg_idx register index, i_cfg_data value
//
//  clear, erase and ignored keys give a registered result as they leave
//  the queue; an append that needs a compare checks the newest characters
//  through the single read port of the character RAM (one character a cycle)
//  a two-entry queue accepts items until full while a result waits on m_axis
//  reset is synchronous, active low; the character RAM needs no clearing pass
// ----------------------------------------------------------------------------
module keystroke_passphrase_suffix_matcher #(
    parameter int STORE_DEPTH = 64,
    parameter int MAX_PHRASE  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] key_code
    input  logic                                s_axis_tuser,   // [0] mode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // [0] matched
    input  logic                                i_cfg_we,
    input  logic [kpsm_pkg::REG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kpsm_pkg::CHARS_W-1:0]        i_cfg_data
);
    import kpsm_pkg::*;

    logic               r_enable;
    logic [LEN_W-1:0]   r_len;
    logic [CHARS_W-1:0] r_chars [4];
    t_cfg               w_cfg;
    logic               w_q_full;
    logic               w_q_push;
    t_op                w_push_op;
    logic               w_q_valid;
    logic               w_q_pop;
    t_op                w_pop_op;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_len      <= '0;
            r_chars[0] <= '0;
            r_chars[1] <= '0;
            r_chars[2] <= '0;
            r_chars[3] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ENABLE:  r_enable   <= i_cfg_data[0];
                REG_LENGTH:  r_len      <= i_cfg_data[LEN_W-1:0];
                REG_CHARS_0: r_chars[0] <= i_cfg_data;
                REG_CHARS_1: r_chars[1] <= i_cfg_data;
                REG_CHARS_2: r_chars[2] <= i_cfg_data;
                REG_CHARS_3: r_chars[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg.enable = r_enable;
    assign w_cfg.len    = r_len;
    assign w_cfg.chars  = {r_chars[3], r_chars[2], r_chars[1], r_chars[0]};

    kpsm_front #(
        .MAX_PHRASE (MAX_PHRASE)
    ) u_front (
        .i_cfg         (w_cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_op        (w_push_op)
    );

    kpsm_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_op    (w_push_op),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_op    (w_pop_op)
    );

    kpsm_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_op        (w_pop_op),
        .o_q_pop       (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
